>>> rtl/lbt_pkg.sv
package lbt_pkg;

	localparam int LINE_SLOTS_DEF  = 1024;
	localparam int OFFSET_BITS_DEF = 24;

	// command codes
	localparam logic [2:0] CMD_OPEN   = 3'd0;
	localparam logic [2:0] CMD_ADD    = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_LOCATE = 3'd3;
	localparam logic [2:0] CMD_BOUNDS = 3'd4;

	// result status codes
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_RANGE = 2'd2;

	// per-cycle strobes broadcast to every cell (at most one set)
	typedef struct packed {
		logic cap;    // capture compare flags against the keys
		logic grow;   // open span: raise entries at/after the located line
		logic ins;    // add boundary: insert key_a, move upper entries up one
		logic trim;   // remove span: lower entries past the span
		logic shift;  // remove span: move entries at/after the span start down one
	} lbt_ctl_t;

endpackage

>>> rtl/lbt_if.sv
interface lbt_req_if import lbt_pkg::*; #(
	parameter int LINE_SLOTS  = LINE_SLOTS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
);
	localparam int IDX_W = $clog2(LINE_SLOTS);

	logic                   valid;
	logic                   ready;
	logic [2:0]             command;
	logic [OFFSET_BITS-1:0] offset;
	logic [OFFSET_BITS-1:0] span_length;
	logic [IDX_W-1:0]       line_number;

	modport source (output valid, command, offset, span_length, line_number, input ready);
	modport sink   (input valid, command, offset, span_length, line_number, output ready);
endinterface

interface lbt_rsp_if import lbt_pkg::*; #(
	parameter int LINE_SLOTS  = LINE_SLOTS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
);
	localparam int IDX_W = $clog2(LINE_SLOTS);

	logic                   valid;
	logic                   ready;
	logic [1:0]             status;
	logic [IDX_W-1:0]       first_line;
	logic [IDX_W:0]         end_line;
	logic [OFFSET_BITS-1:0] line_start;
	logic [OFFSET_BITS-1:0] line_stop;
	logic [IDX_W:0]         line_total;

	modport source (output valid, status, first_line, end_line, line_start, line_stop,
		line_total, input ready);
	modport sink   (input valid, status, first_line, end_line, line_start, line_stop,
		line_total, output ready);
endinterface

>>> rtl/lbt_cell.sv
module lbt_cell import lbt_pkg::*; #(
	parameter int IDX         = 0,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int IDX_W       = 10,
	parameter int CNT_W       = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lbt_ctl_t               ctl,
	input  logic [OFFSET_BITS-1:0] key_a,
	input  logic [OFFSET_BITS:0]   key_b,
	input  logic [OFFSET_BITS-1:0] len,
	input  logic [CNT_W-1:0]       count,
	input  logic                   beg_en,
	input  logic [IDX_W-1:0]       sel_beg,
	input  logic [IDX_W-1:0]       sel_end,
	input  logic                   prev_flag_a,
	input  logic                   prev_flag_b,
	input  logic [OFFSET_BITS-1:0] prev_val,
	input  logic [OFFSET_BITS-1:0] next_val,
	output logic                   flag_a,
	output logic                   flag_b,
	output logic                   oh_a,
	output logic                   oh_b,
	output logic [OFFSET_BITS-1:0] val,
	output logic [OFFSET_BITS-1:0] beg_v,
	output logic [OFFSET_BITS-1:0] end_v
);

	logic                   flag_a_q, flag_b_q;
	logic [OFFSET_BITS-1:0] val_q;
	logic                   interior, live, reach;

	// interior: below the end entry; live: holds an entry; reach: live or next free
	assign interior = CNT_W'(IDX + 1) < count;
	assign live     = CNT_W'(IDX) < count;
	assign reach    = CNT_W'(IDX) <= count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_a_q <= 1'b0;
			flag_b_q <= 1'b0;
			val_q    <= '0;
		end else begin
			if (ctl.cap) begin
				flag_a_q <= interior && (val_q <= key_a);
				flag_b_q <= interior && ({1'b0, val_q} <= key_b);
			end
			if (ctl.grow) begin
				if (!flag_a_q && live)
					val_q <= val_q + len;
			end else if (ctl.ins) begin
				if (!flag_a_q && reach)
					val_q <= prev_flag_a ? key_a : prev_val;
			end else if (ctl.trim) begin
				if (!flag_b_q && live)
					val_q <= val_q - len;
			end else if (ctl.shift) begin
				if (!flag_a_q)
					val_q <= next_val;
			end
		end
	end

	// flags run ones then zeros along the chain; first zero marks the located line
	assign flag_a = flag_a_q;
	assign flag_b = flag_b_q;
	assign oh_a   = !flag_a_q && prev_flag_a;
	assign oh_b   = !flag_b_q && prev_flag_b;
	assign val    = val_q;
	assign beg_v  = (beg_en && (sel_beg == IDX_W'(IDX))) ? val_q : '0;
	assign end_v  = (sel_end == IDX_W'(IDX)) ? val_q : '0;

endmodule

>>> rtl/lbt_collect.sv
module lbt_collect import lbt_pkg::*; #(
	parameter int LINE_SLOTS  = LINE_SLOTS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int IDX_W       = 10
) (
	input  logic [LINE_SLOTS-1:0]  oh_a,
	input  logic [LINE_SLOTS-1:0]  oh_b,
	input  logic [OFFSET_BITS-1:0] beg_v [LINE_SLOTS],
	input  logic [OFFSET_BITS-1:0] end_v [LINE_SLOTS],
	output logic [IDX_W-1:0]       idx_a,
	output logic [IDX_W-1:0]       idx_b,
	output logic [OFFSET_BITS-1:0] beg,
	output logic [OFFSET_BITS-1:0] stop
);

	// OR trees: one-hot to index, and gather of the single selected cell
	always_comb begin
		idx_a = '0;
		idx_b = '0;
		beg   = '0;
		stop  = '0;
		for (int i = 0; i < LINE_SLOTS; i++) begin
			idx_a = idx_a | (oh_a[i] ? IDX_W'(i) : '0);
			idx_b = idx_b | (oh_b[i] ? IDX_W'(i) : '0);
			beg   = beg | beg_v[i];
			stop  = stop | end_v[i];
		end
	end

endmodule

>>> rtl/line_boundary_table_top.sv
// Sorted line-start table for a text buffer of up to LINE_SLOTS entries; the last
// entry is the document end and reset leaves a single entry of zero. Each entry
// lives in its own cell of a chain; a command is taken on the req channel and
// answered by exactly one beat on rsp. Steps: every cell compares at accept
// (S_IDLE), the line is located and the table updated (S_ENC), then the selected
// line is read and the result loaded into the rsp register (S_READ). A remove
// span that drops boundaries passes through S_SHIFT before S_READ, where the
// chain closes the gap one slot per cycle. A new command is accepted once the
// previous one has loaded its result; if the rsp register is still held by the
// sink, the read cycle waits for it.
// Errors (full table, overrun, unknown command) leave the table untouched.
module line_boundary_table_top import lbt_pkg::*; #(
	parameter int LINE_SLOTS  = LINE_SLOTS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lbt_req_if.sink   req,
	lbt_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(LINE_SLOTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int OB    = OFFSET_BITS;

	typedef enum logic [1:0] {
		S_IDLE,   // accept; cells compare against the incoming keys
		S_ENC,    // locate result encoded, table updated
		S_SHIFT,  // remove span: close the gap one slot per cycle
		S_READ    // gather line begin/end, load the rsp register
	} state_t;

	state_t           state_q;
	logic [2:0]       cmd_q;
	logic [OB-1:0]    off_q, len_q;
	logic [IDX_W-1:0] qline_q;
	logic [1:0]       status_q;
	logic [IDX_W-1:0] first_q, gap_q;
	logic [CNT_W-1:0] last_q;
	logic [CNT_W-1:0] count_q;
	logic [OB-1:0]    end_q;     // mirror of the end entry

	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [IDX_W-1:0] out_first_q;
	logic [CNT_W-1:0] out_last_q, out_total_q;
	logic [OB-1:0]    out_start_q, out_stop_q;

	// accept-time range checks
	logic [OB:0]      sum_ol, end_len;
	logic [1:0]       acc_status;
	logic             accept;

	// cell chain wiring
	lbt_ctl_t              ctl;
	logic [OB-1:0]         key_a;
	logic [LINE_SLOTS-1:0] flag_a, flag_b, oh_a, oh_b, prev_fa, prev_fb;
	logic [OB-1:0]         val [LINE_SLOTS];
	logic [OB-1:0]         prev_val [LINE_SLOTS];
	logic [OB-1:0]         next_val [LINE_SLOTS];
	logic [OB-1:0]         beg_v [LINE_SLOTS];
	logic [OB-1:0]         end_v [LINE_SLOTS];
	logic [IDX_W-1:0]      idx_a, idx_b;
	logic [OB-1:0]         beg, stop;

	// read select
	logic [CNT_W-1:0] first_ext, cnt_m1;
	logic             beg_en;
	logic [IDX_W-1:0] sel_beg, sel_end;
	logic             out_free;
	logic             load_rsp;

	assign accept  = req.valid && req.ready;
	assign sum_ol  = {1'b0, req.offset} + {1'b0, req.span_length};
	assign end_len = {1'b0, end_q} + {1'b0, req.span_length};

	always_comb begin
		acc_status = STS_OK;
		case (req.command)
			CMD_OPEN: begin
				if (req.offset > end_q || end_len[OB])
					acc_status = STS_RANGE;
			end
			CMD_ADD: begin
				if (count_q >= CNT_W'(LINE_SLOTS))
					acc_status = STS_FULL;
				else if (req.offset > end_q)
					acc_status = STS_RANGE;
			end
			CMD_REMOVE: begin
				if (sum_ol > {1'b0, end_q})
					acc_status = STS_RANGE;
			end
			CMD_LOCATE: acc_status = STS_OK;
			CMD_BOUNDS: acc_status = STS_OK;
			default:    acc_status = STS_RANGE;
		endcase
	end

	// strobes to the chain
	always_comb begin
		ctl       = '0;
		ctl.cap   = accept;
		ctl.grow  = state_q == S_ENC && status_q == STS_OK && cmd_q == CMD_OPEN;
		ctl.ins   = state_q == S_ENC && status_q == STS_OK && cmd_q == CMD_ADD;
		ctl.trim  = state_q == S_ENC && status_q == STS_OK && cmd_q == CMD_REMOVE;
		ctl.shift = state_q == S_SHIFT;
	end

	// key_a doubles as the inserted value during the update cycle
	assign key_a = (state_q == S_IDLE) ? req.offset : off_q;

	// neighbor hand-off; the chain bottom sees a set flag so it can take an insert
	assign prev_fa = {flag_a[LINE_SLOTS-2:0], 1'b1};
	assign prev_fb = {flag_b[LINE_SLOTS-2:0], 1'b1};

	// line begin: entry first-1 (none for line 0); past the table both ends are
	// the document end
	assign first_ext = {1'b0, first_q};
	assign cnt_m1    = count_q - 1'b1;
	assign beg_en    = first_q != '0;
	assign sel_beg   = (first_ext >= count_q) ? cnt_m1[IDX_W-1:0] : first_q - 1'b1;
	assign sel_end   = (first_ext >= cnt_m1) ? cnt_m1[IDX_W-1:0] : first_q;

	for (genvar g = 0; g < LINE_SLOTS; g++) begin : g_cell
		if (g == 0) begin : g_lo
			assign prev_val[g] = '0;
		end else begin : g_lo
			assign prev_val[g] = val[g-1];
		end
		if (g == LINE_SLOTS - 1) begin : g_hi
			assign next_val[g] = val[g];
		end else begin : g_hi
			assign next_val[g] = val[g+1];
		end

		lbt_cell #(
			.IDX         (g),
			.OFFSET_BITS (OB),
			.IDX_W       (IDX_W),
			.CNT_W       (CNT_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.key_a       (key_a),
			.key_b       (sum_ol),
			.len         (len_q),
			.count       (count_q),
			.beg_en      (beg_en),
			.sel_beg     (sel_beg),
			.sel_end     (sel_end),
			.prev_flag_a (prev_fa[g]),
			.prev_flag_b (prev_fb[g]),
			.prev_val    (prev_val[g]),
			.next_val    (next_val[g]),
			.flag_a      (flag_a[g]),
			.flag_b      (flag_b[g]),
			.oh_a        (oh_a[g]),
			.oh_b        (oh_b[g]),
			.val         (val[g]),
			.beg_v       (beg_v[g]),
			.end_v       (end_v[g])
		);
	end

	lbt_collect #(
		.LINE_SLOTS  (LINE_SLOTS),
		.OFFSET_BITS (OB),
		.IDX_W       (IDX_W)
	) u_collect (
		.oh_a  (oh_a),
		.oh_b  (oh_b),
		.beg_v (beg_v),
		.end_v (end_v),
		.idx_a (idx_a),
		.idx_b (idx_b),
		.beg   (beg),
		.stop  (stop)
	);

	assign out_free  = !out_valid_q || rsp.ready;
	assign load_rsp  = state_q == S_READ && out_free;
	assign req.ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= CNT_W'(1);
			end_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STS_OK;
		end else begin
			// a new result and the drain of the old one can meet in one cycle
			if (load_rsp)
				out_valid_q <= 1'b1;
			else if (rsp.valid && rsp.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= req.command;
						off_q    <= req.offset;
						len_q    <= req.span_length;
						qline_q  <= req.line_number;
						status_q <= acc_status;
						state_q  <= S_ENC;
					end
				end
				S_ENC: begin
					first_q <= '0;
					last_q  <= '0;
					state_q <= S_READ;
					if (status_q == STS_OK) begin
						case (cmd_q)
							CMD_OPEN: begin
								first_q <= idx_a;
								last_q  <= CNT_W'(idx_a);
								end_q   <= end_q + len_q;
							end
							CMD_ADD: begin
								first_q <= idx_a;
								last_q  <= CNT_W'(idx_a) + 1'b1;
								count_q <= count_q + 1'b1;
							end
							CMD_REMOVE: begin
								first_q <= idx_a;
								last_q  <= CNT_W'(idx_b);
								gap_q   <= idx_b - idx_a;
								end_q   <= end_q - len_q;
								if (idx_b != idx_a)
									state_q <= S_SHIFT;
							end
							CMD_LOCATE: begin
								first_q <= idx_a;
								last_q  <= CNT_W'(idx_a) + 1'b1;
							end
							default: begin
								first_q <= qline_q;
								last_q  <= CNT_W'(qline_q) + 1'b1;
							end
						endcase
					end
				end
				S_SHIFT: begin
					// one dropped boundary leaves the table per cycle
					gap_q   <= gap_q - 1'b1;
					count_q <= count_q - 1'b1;
					if (gap_q == IDX_W'(1))
						state_q <= S_READ;
				end
				S_READ: begin
					if (out_free) begin
						out_status_q <= status_q;
						out_total_q  <= count_q;
						if (status_q == STS_OK) begin
							out_first_q <= first_q;
							out_last_q  <= last_q;
							out_start_q <= beg;
							out_stop_q  <= stop;
						end else begin
							out_first_q <= '0;
							out_last_q  <= '0;
							out_start_q <= '0;
							out_stop_q  <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.first_line = out_first_q;
	assign rsp.end_line   = out_last_q;
	assign rsp.line_start = out_start_q;
	assign rsp.line_stop  = out_stop_q;
	assign rsp.line_total = out_total_q;

	// gap closing only runs for a remove span with boundaries left to drop
	a_shift_remove: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> (cmd_q == CMD_REMOVE && gap_q != '0))
		else $error("shift state without a pending remove");

	// entry count only moves in the update and gap-closing cycles
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_READ) |=> $stable(count_q))
		else $error("entry count changed outside an update");

	// add boundary on a full table must report full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.command == CMD_ADD && count_q == CNT_W'(LINE_SLOTS))
		|=> status_q == STS_FULL)
		else $error("full table not flagged");

	// a held result is never overwritten by the next one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && rsp.valid && !rsp.ready)
		|=> (state_q == S_READ && $stable(rsp.first_line) && $stable(rsp.line_start)))
		else $error("result register overwritten while held");

endmodule

>>> tb/line_boundary_table_top_tb.sv
module line_boundary_table_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lbt_pkg::*;

	localparam int LS    = LINE_SLOTS_DEF;
	localparam int OB    = OFFSET_BITS_DEF;
	localparam int IDX_W = $clog2(LS);
	localparam longint unsigned OFF_MAX = (64'd1 << OB) - 1;

	// one request beat as the sender builds it
	typedef struct {
		logic [2:0]       command;
		logic [OB-1:0]    offset;
		logic [OB-1:0]    span_length;
		logic [IDX_W-1:0] line_number;
	} table_cmd_t;

	// one response beat, field for field as on the rsp channel
	typedef struct {
		logic [1:0]       status;
		logic [IDX_W-1:0] first_line;
		logic [IDX_W:0]   end_line;
		logic [OB-1:0]    line_start;
		logic [OB-1:0]    line_stop;
		logic [IDX_W:0]   line_total;
	} table_rsp_t;

	// Shadow copy of the line table. Every accepted command without error updates it;
	// each queues the response the block owes for it; responses are matched in order.
	class boundary_ledger;
		logic [OB-1:0] starts [LS];
		int unsigned   lines;
		table_rsp_t    due_results [$];
		int unsigned   mismatches;

		function new();
			starts[0]  = '0;
			lines      = 1;
			mismatches = 0;
		endfunction

		function longint unsigned doc_end();
			return starts[lines - 1];
		endfunction

		// line that holds a text offset; at or past the end it is the last line
		function int unsigned line_of(longint unsigned off);
			int unsigned n;
			n = 0;
			if (off >= doc_end())
				return lines - 1;
			for (int unsigned i = 0; i + 1 < lines; i++)
				if (starts[i] <= off)
					n++;
			return n;
		endfunction

		function longint unsigned begin_of(int unsigned ln);
			if (ln == 0)
				return 0;
			if (ln >= lines)
				return doc_end();
			return starts[ln - 1];
		endfunction

		function longint unsigned end_of(int unsigned ln);
			if (ln >= lines)
				return doc_end();
			return starts[ln];
		endfunction

		function void note_command(table_cmd_t c);
			table_rsp_t       r;
			longint unsigned  off, len, de;
			int unsigned      first, last, pos, lo, hi, gap;
			off   = c.offset;
			len   = c.span_length;
			de    = doc_end();
			first = 0;
			last  = 0;
			r.status = STS_OK;
			case (c.command)
				CMD_OPEN: begin
					if (off > de || de + len > OFF_MAX) begin
						r.status = STS_RANGE;
					end else begin
						first = line_of(off);
						last  = first;
						for (int unsigned i = first; i < lines; i++)
							starts[i] = starts[i] + OB'(len);
					end
				end
				CMD_ADD: begin
					if (lines >= LS) begin
						r.status = STS_FULL;
					end else if (off > de) begin
						r.status = STS_RANGE;
					end else begin
						pos = 0;
						for (int unsigned i = 0; i + 1 < lines; i++)
							if (starts[i] <= off)
								pos++;
						for (int unsigned i = lines; i > pos; i--)
							starts[i] = starts[i - 1];
						starts[pos] = OB'(off);
						lines++;
						first = pos;
						last  = pos + 1;
					end
				end
				CMD_REMOVE: begin
					if (off + len > de) begin
						r.status = STS_RANGE;
					end else begin
						lo  = line_of(off);
						hi  = line_of(off + len);
						gap = hi - lo;
						for (int unsigned i = 0; i < lines - hi; i++)
							starts[lo + i] = starts[hi + i];
						lines -= gap;
						for (int unsigned i = lo; i < lines; i++)
							starts[i] = starts[i] - OB'(len);
						first = lo;
						last  = hi;
					end
				end
				CMD_LOCATE: begin
					first = line_of(off);
					last  = first + 1;
				end
				CMD_BOUNDS: begin
					first = c.line_number;
					last  = first + 1;
				end
				default: r.status = STS_RANGE;
			endcase
			if (r.status == STS_OK) begin
				r.first_line = IDX_W'(first);
				r.end_line   = (IDX_W + 1)'(last);
				r.line_start = OB'(begin_of(first));
				r.line_stop  = OB'(end_of(first));
			end else begin
				r.first_line = '0;
				r.end_line   = '0;
				r.line_start = '0;
				r.line_stop  = '0;
			end
			r.line_total = (IDX_W + 1)'(lines);
			due_results.insert(due_results.size(), r);
		endfunction

		function void compare(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$display("%0t ns  %s mismatch: expected %0d, actual %0d",
					$time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(table_rsp_t got);
			table_rsp_t want;
			if (due_results.size() == 0) begin
				$display("%0t ns  unexpected response beat: expected none, actual status %0d",
					$time, got.status);
				mismatches++;
				return;
			end
			want = due_results.pop_front();
			compare("status",     want.status,     got.status);
			compare("first_line", want.first_line, got.first_line);
			compare("end_line",   want.end_line,   got.end_line);
			compare("line_start", want.line_start, got.line_start);
			compare("line_stop",  want.line_stop,  got.line_stop);
			compare("line_total", want.line_total, got.line_total);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lbt_req_if #(.LINE_SLOTS(LS), .OFFSET_BITS(OB)) req_ch ();
	lbt_rsp_if #(.LINE_SLOTS(LS), .OFFSET_BITS(OB)) rsp_ch ();

	line_boundary_table_top #(
		.LINE_SLOTS  (LS),
		.OFFSET_BITS (OB)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	boundary_ledger ledger;

	// idle odds in percent per cycle; changed per phase
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

	// response side: ready toggles at the falling edge per the current odds
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// response monitor: every beat taken is checked against the oldest prediction
	always @(posedge clk) begin
		table_rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status     = rsp_ch.status;
			got.first_line = rsp_ch.first_line;
			got.end_line   = rsp_ch.end_line;
			got.line_start = rsp_ch.line_start;
			got.line_stop  = rsp_ch.line_stop;
			got.line_total = rsp_ch.line_total;
			ledger.check_result(got);
		end
	end

	function automatic logic [OB-1:0] rand_off();
		return OB'($urandom());
	endfunction

	function automatic logic [IDX_W-1:0] rand_line();
		return IDX_W'($urandom());
	endfunction

	// Drive one command beat. Random idle cycles come first, then the beat is
	// held until ready is seen at a rising edge; the ledger is updated at accept.
	task automatic issue(input logic [2:0] cmd, input longint unsigned off,
		input longint unsigned len, input int unsigned ln);
		table_cmd_t c;
		c.command     = cmd;
		c.offset      = OB'(off);
		c.span_length = OB'(len);
		c.line_number = IDX_W'(ln);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid       <= 1'b1;
		req_ch.command     <= c.command;
		req_ch.offset      <= c.offset;
		req_ch.span_length <= c.span_length;
		req_ch.line_number <= c.line_number;
		do
			@(posedge clk);
		while (!req_ch.ready);
		ledger.note_command(c);
	endtask

	// Mostly well-formed edits: an open span followed by the newlines it carries,
	// removals, lookups. The rest is noise, including unknown commands.
	task automatic random_burst(input int unsigned n);
		int unsigned     done, sel, k, ln;
		longint unsigned de, off, len, room, cap;
		done = 0;
		while (done < n) begin
			de  = ledger.doc_end();
			sel = $urandom_range(99);
			if (sel < 30) begin
				// text insert: open the span, then one add per newline inside it
				off  = $urandom_range(de, 0);
				room = OFF_MAX - de;
				len  = ($urandom_range(9) == 0) ? $urandom_range(60000, 1)
					: $urandom_range(3000, 1);
				if (len > room)
					len = room;
				issue(CMD_OPEN, off, len, rand_line());
				k = $urandom_range(4, 0);
				repeat (k)
					issue(CMD_ADD, $urandom_range(off + len, off), rand_off(), rand_line());
				done += 1 + k;
			end else if (sel < 45) begin
				off = $urandom_range(de, 0);
				if ($urandom_range(49) == 0) begin
					// wipe the whole document
					off = 0;
					len = de;
				end else if ($urandom_range(4) == 0) begin
					len = $urandom_range(de - off, 0);
				end else begin
					cap = (de - off < 400) ? de - off : 400;
					len = $urandom_range(cap, 0);
				end
				issue(CMD_REMOVE, off, len, rand_line());
				done++;
			end else if (sel < 60) begin
				off = ($urandom_range(4) == 0) ? rand_off() : $urandom_range(de + 10, 0);
				issue(CMD_LOCATE, off, rand_off(), rand_line());
				done++;
			end else if (sel < 75) begin
				ln = ledger.lines + 1;
				if (ln > LS - 1)
					ln = LS - 1;
				ln = ($urandom_range(4) == 0) ? rand_line() : $urandom_range(ln, 0);
				issue(CMD_BOUNDS, rand_off(), rand_off(), ln);
				done++;
			end else if (sel < 85) begin
				// lone boundary, now and then just past the end
				off = $urandom_range(de, 0);
				if ($urandom_range(7) == 0 && de < OFF_MAX)
					off = de + 1;
				issue(CMD_ADD, off, rand_off(), rand_line());
				done++;
			end else begin
				issue(3'($urandom_range(7, 0)), rand_off(), rand_off(), rand_line());
				done++;
			end
		end
	endtask

	initial begin
		longint unsigned de;
		ledger = new();

		// all inputs known from time zero
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.command     = CMD_LOCATE;
		req_ch.offset      = '0;
		req_ch.span_length = '0;
		req_ch.line_number = '0;
		src_idle_pct       = 14;
		snk_idle_pct       = 58;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// ---- directed: empty table, extremes, every command and error path ----
		issue(CMD_LOCATE, 0, 0, 0);              // single empty line
		issue(CMD_BOUNDS, 0, 0, 0);
		issue(CMD_BOUNDS, 0, 0, LS - 1);         // far past the table
		issue(CMD_ADD, 0, 0, 0);                 // boundary at the end of an empty doc
		issue(CMD_ADD, 1, 0, 0);                 // above the end
		issue(CMD_OPEN, 1, 5, 0);                // open past the end
		issue(CMD_OPEN, 0, OFF_MAX, 0);          // end lands exactly on the top offset
		issue(CMD_OPEN, 0, 1, 0);                // one more character overruns
		issue(CMD_LOCATE, OFF_MAX, 0, 0);        // at the end: last line
		issue(CMD_ADD, OFF_MAX, OFF_MAX, LS - 1); // boundary equal to the end
		issue(CMD_BOUNDS, 0, 0, 1);
		issue(CMD_REMOVE, OFF_MAX, 1, 0);        // remove running past the end
		issue(CMD_REMOVE, 0, OFF_MAX, 0);        // remove everything
		issue(CMD_REMOVE, 0, 0, 0);              // empty span
		for (int u = CMD_BOUNDS + 1; u < 8; u++)
			issue(3'(u), rand_off(), rand_off(), rand_line());
		issue(CMD_OPEN, 0, 100, 0);
		issue(CMD_ADD, 50, 0, 0);
		issue(CMD_ADD, 50, 0, 0);                // duplicate boundary
		issue(CMD_ADD, 0, 0, 0);                 // boundary at offset zero
		issue(CMD_LOCATE, 49, 0, 0);
		issue(CMD_LOCATE, 50, 0, 0);
		issue(CMD_REMOVE, 40, 20, 0);            // drops the boundaries inside
		issue(CMD_OPEN, 30, 7, 0);               // open in the middle
		issue(CMD_BOUNDS, 0, 0, ledger.lines);   // first line past the table

		// ---- phase A: sender idles a little, receiver a lot ----
		random_burst(150);

		// ---- phase B: the other way round ----
		src_idle_pct = 58;
		snk_idle_pct = 14;
		random_burst(150);

		// ---- phase C: no idling; fill the table to the top, then churn ----
		src_idle_pct = 0;
		snk_idle_pct = 0;
		if (ledger.doc_end() < 5000)
			issue(CMD_OPEN, 0, 200000, 0);
		while (ledger.lines < LS) begin
			de = ledger.doc_end();
			issue(CMD_ADD, $urandom_range(de, 0), rand_off(), rand_line());
		end
		de = ledger.doc_end();
		issue(CMD_ADD, $urandom_range(de, 0), 0, 0); // full table
		issue(CMD_ADD, de + 1, 0, 0);                // full wins over overrun
		issue(CMD_LOCATE, OFF_MAX, 0, 0);            // last line of a full table
		issue(CMD_BOUNDS, 0, 0, LS - 1);
		issue(CMD_BOUNDS, 0, 0, LS - 2);
		issue(CMD_OPEN, 0, 10, 0);
		de = ledger.doc_end();
		issue(CMD_REMOVE, de / 4, de / 2, 0);        // long gap to close
		random_burst(60);

		// drain
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (ledger.due_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (ledger.mismatches == 0 && ledger.due_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/lbt_pkg.sv
rtl/lbt_if.sv
rtl/lbt_cell.sv
rtl/lbt_collect.sv
rtl/line_boundary_table_top.sv
tb/line_boundary_table_top_tb.sv
